// ===== hw/rtl/fca_pkg.sv =====
package fca_pkg;

  // Field widths of the request, result and configuration words.
  localparam int KIND_W    = 2;
  localparam int LEN_W     = 24;
  localparam int IDX_W     = 12;
  localparam int VAL_W     = 32;
  localparam int COUNT_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;

  // Running byte total of the chain; it never exceeds length plus one block.
  localparam int ACC_W = 26;

  localparam int TABLE_DEPTH_DEF = 4096;

  localparam logic [VAL_W-1:0] CHAIN_END = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] ENTRY_FREE = 32'h0000_0000;

  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 13'd4096;
  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST    = 13'd512;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd1;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Microprogram addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] U_CLEAR = 4'd1;
  localparam logic [UPC_W-1:0] U_READ  = 4'd2;
  localparam logic [UPC_W-1:0] U_CAPT  = 4'd3;
  localparam logic [UPC_W-1:0] U_WRITE = 4'd4;
  localparam logic [UPC_W-1:0] U_AINIT = 4'd5;
  localparam logic [UPC_W-1:0] U_SCAN  = 4'd6;
  localparam logic [UPC_W-1:0] U_LINK  = 4'd7;
  localparam logic [UPC_W-1:0] U_TERM  = 4'd8;
  localparam logic [UPC_W-1:0] U_NOSP  = 4'd9;
  localparam logic [UPC_W-1:0] U_OUT   = 4'd10;

  // Datapath operations.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
  localparam logic [OP_W-1:0] OP_READ    = 4'd2;
  localparam logic [OP_W-1:0] OP_CAPTURE = 4'd3;
  localparam logic [OP_W-1:0] OP_WRITE   = 4'd4;
  localparam logic [OP_W-1:0] OP_AINIT   = 4'd5;
  localparam logic [OP_W-1:0] OP_SCAN    = 4'd6;
  localparam logic [OP_W-1:0] OP_LINK    = 4'd7;
  localparam logic [OP_W-1:0] OP_TERM    = 4'd8;
  localparam logic [OP_W-1:0] OP_NOSPACE = 4'd9;

  // Sequencing conditions.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_GOTO   = 3'd0;
  localparam logic [COND_W-1:0] COND_START  = 3'd1;
  localparam logic [COND_W-1:0] COND_CLEAR  = 3'd2;
  localparam logic [COND_W-1:0] COND_SCAN   = 3'd3;
  localparam logic [COND_W-1:0] COND_ENOUGH = 3'd4;

  // One control word of the microprogram.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  tgt_a;
    logic [UPC_W-1:0]  tgt_b;
    logic              strobe;
  } ctl_word_t;

  // The microprogram itself.
  function automatic ctl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctl_word_t w;
    w = '{op: OP_NONE, cond: COND_GOTO, tgt_a: U_IDLE, tgt_b: U_IDLE, strobe: 1'b0};
    case (upc)
      U_IDLE:  w = '{OP_NONE,    COND_START,  U_IDLE, U_IDLE, 1'b0};
      U_CLEAR: w = '{OP_CLEAR,   COND_CLEAR,  U_IDLE, U_IDLE, 1'b0};
      U_READ:  w = '{OP_READ,    COND_GOTO,   U_CAPT, U_IDLE, 1'b0};
      U_CAPT:  w = '{OP_CAPTURE, COND_GOTO,   U_OUT,  U_IDLE, 1'b0};
      U_WRITE: w = '{OP_WRITE,   COND_GOTO,   U_OUT,  U_IDLE, 1'b0};
      U_AINIT: w = '{OP_AINIT,   COND_GOTO,   U_SCAN, U_IDLE, 1'b0};
      U_SCAN:  w = '{OP_SCAN,    COND_SCAN,   U_LINK, U_NOSP, 1'b0};
      U_LINK:  w = '{OP_LINK,    COND_ENOUGH, U_TERM, U_SCAN, 1'b0};
      U_TERM:  w = '{OP_TERM,    COND_GOTO,   U_OUT,  U_IDLE, 1'b0};
      U_NOSP:  w = '{OP_NOSPACE, COND_GOTO,   U_OUT,  U_IDLE, 1'b0};
      U_OUT:   w = '{OP_NONE,    COND_GOTO,   U_IDLE, U_IDLE, 1'b1};
      default: w = '{OP_NONE,    COND_GOTO,   U_IDLE, U_IDLE, 1'b0};
    endcase
    return w;
  endfunction

  // Entry point of the microprogram for each request kind.
  function automatic logic [UPC_W-1:0] dispatch(input logic [KIND_W-1:0] kind);
    logic [UPC_W-1:0] t;
    case (kind)
      KIND_ALLOC: t = U_AINIT;
      KIND_READ:  t = U_READ;
      KIND_WRITE: t = U_WRITE;
      default:    t = U_OUT;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/fat_chain_allocator.sv =====
// Allocation table chain builder.
// A request word is taken on a cycle where start is high and busy is low. The
// kind field selects allocate, read entry or write entry; kind 3 returns an
// all-zero result. Every request gives one result word, shown on the out_
// ports for exactly one cycle while out_valid is high; the receiver cannot
// hold it off, and no new request is taken until that cycle is over.
// Configuration words (scan limit, block size) go in through cfg_valid /
// cfg_ready and are to be written only while the block is idle; the block
// itself does not enforce this. cfg_ready is always high. A read passes
// through read, capture and output steps, a write through write and output,
// and an unused kind goes straight to output. An allocation walks the table
// one entry per cycle through the single read port of the table memory,
// pausing for a link step for each block linked, then terminates the chain
// or flags no space before the output step. The next request may start
// right after the result cycle. After reset the block runs a clearing pass
// that zeroes every table entry, one entry a cycle; busy stays high during it.
module fat_chain_allocator #(
  parameter int TABLE_DEPTH = fca_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fca_pkg::KIND_W-1:0]    in_kind,
  input  logic [fca_pkg::LEN_W-1:0]     in_byte_length,
  input  logic [fca_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [fca_pkg::VAL_W-1:0]     in_entry_value,
  output logic                          out_valid,
  output logic [fca_pkg::IDX_W-1:0]     out_start_block,
  output logic [fca_pkg::COUNT_W-1:0]   out_blocks_linked,
  output logic                          out_no_space,
  output logic [fca_pkg::VAL_W-1:0]     out_read_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fca_pkg::CFG_W-1:0]     cfg_data
);
  import fca_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = AW + 1;

  // Table memory.
  logic [VAL_W-1:0] mem [TABLE_DEPTH];
  logic [VAL_W-1:0] rdata_r;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;

  // Sequencer.
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ctl_word_t        ctl;

  // Configuration registers.
  logic [CFG_W-1:0] blocks_in_use_r;
  logic [CFG_W-1:0] block_size_r;

  // Datapath registers.
  logic [AW-1:0]      clr_ptr_r, clr_ptr_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [PW-1:0]      scan_ptr_r, scan_ptr_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [COUNT_W-1:0] linked_r, linked_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [IDX_W-1:0]   start_block_r, start_block_nxt;
  logic               no_space_r, no_space_nxt;
  logic [VAL_W-1:0]   read_value_r, read_value_nxt;

  // Derived values.
  logic               accept;
  logic [PW-1:0]      limit;
  logic [CFG_W-1:0]   bs_eff;
  logic [ACC_W-1:0]   acc_sum;
  logic               enough;
  logic               idx_ok;
  logic               issue;
  logic               found;
  logic               exhausted;

  assign ctl       = ucode_rom(upc_r);
  assign busy      = (upc_r != U_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Scan limit is the configured count, capped at the table depth.
  assign limit = (32'(blocks_in_use_r) >= 32'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH)
                                                             : PW'(blocks_in_use_r);
  assign bs_eff  = (block_size_r == '0) ? CFG_W'(1) : block_size_r;
  assign acc_sum = acc_r + ACC_W'(bs_eff);
  // The chain is long enough once blocks times block size covers the length.
  assign enough  = (acc_sum >= ACC_W'(len_r));
  assign idx_ok  = (32'(idx_r) < 32'(TABLE_DEPTH));

  // Scan pipeline: one read per cycle until a hit; data tested next cycle.
  assign issue     = (scan_ptr_r < limit);
  assign found     = pend_valid_r && (rdata_r == ENTRY_FREE);
  assign exhausted = !pend_valid_r && !issue;

  // Next microprogram address.
  always_comb begin
    upc_nxt = upc_r;
    case (ctl.cond)
      COND_GOTO:   upc_nxt = ctl.tgt_a;
      COND_START:  upc_nxt = accept ? dispatch(in_kind) : upc_r;
      COND_CLEAR:  upc_nxt = (clr_ptr_r == AW'(TABLE_DEPTH - 1)) ? ctl.tgt_a : upc_r;
      COND_SCAN: begin
        if (found) begin
          upc_nxt = ctl.tgt_a;
        end else if (exhausted) begin
          upc_nxt = ctl.tgt_b;
        end
      end
      COND_ENOUGH: upc_nxt = enough ? ctl.tgt_a : ctl.tgt_b;
      default:     upc_nxt = U_IDLE;
    endcase
  end

  // Datapath driven by the current control word.
  always_comb begin
    we              = 1'b0;
    waddr           = cur_r;
    wdata           = ENTRY_FREE;
    raddr           = scan_ptr_r[AW-1:0];
    clr_ptr_nxt     = clr_ptr_r;
    len_nxt         = len_r;
    idx_nxt         = idx_r;
    val_nxt         = val_r;
    scan_ptr_nxt    = scan_ptr_r;
    pend_valid_nxt  = pend_valid_r;
    pend_addr_nxt   = pend_addr_r;
    cur_nxt         = cur_r;
    linked_nxt      = linked_r;
    acc_nxt         = acc_r;
    start_block_nxt = start_block_r;
    no_space_nxt    = no_space_r;
    read_value_nxt  = read_value_r;
    case (ctl.op)
      OP_NONE: begin
        if (accept) begin
          len_nxt         = in_byte_length;
          idx_nxt         = in_entry_index;
          val_nxt         = in_entry_value;
          linked_nxt      = '0;
          start_block_nxt = '0;
          no_space_nxt    = 1'b0;
          read_value_nxt  = '0;
        end
      end
      OP_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_ptr_r;
        wdata       = ENTRY_FREE;
        clr_ptr_nxt = clr_ptr_r + AW'(1);
      end
      OP_READ: begin
        raddr = AW'(32'(idx_r));
      end
      OP_CAPTURE: begin
        read_value_nxt = idx_ok ? rdata_r : '0;
      end
      OP_WRITE: begin
        we    = idx_ok;
        waddr = AW'(32'(idx_r));
        wdata = val_r;
      end
      OP_AINIT: begin
        scan_ptr_nxt   = PW'(1);
        pend_valid_nxt = 1'b0;
        linked_nxt     = '0;
        acc_nxt        = '0;
      end
      OP_SCAN: begin
        // A free entry stays in the pending slot for the link step.
        if (!found) begin
          pend_valid_nxt = issue;
          pend_addr_nxt  = scan_ptr_r[AW-1:0];
          if (issue) begin
            scan_ptr_nxt = scan_ptr_r + PW'(1);
          end
        end
      end
      OP_LINK: begin
        // Link the previous block to the one just found, or record the start.
        if (linked_r == '0) begin
          start_block_nxt = IDX_W'(32'(pend_addr_r));
        end else begin
          we    = 1'b1;
          waddr = cur_r;
          wdata = VAL_W'(pend_addr_r);
        end
        cur_nxt        = pend_addr_r;
        scan_ptr_nxt   = PW'(pend_addr_r) + PW'(1);
        pend_valid_nxt = 1'b0;
        linked_nxt     = linked_r + COUNT_W'(1);
        acc_nxt        = acc_sum;
      end
      OP_TERM: begin
        we    = 1'b1;
        waddr = cur_r;
        wdata = CHAIN_END;
      end
      OP_NOSPACE: begin
        no_space_nxt = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= U_CLEAR;
      clr_ptr_r    <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      upc_r        <= upc_nxt;
      clr_ptr_r    <= clr_ptr_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= BLOCKS_IN_USE_RST;
      block_size_r    <= BLOCK_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_data;
        REG_BLOCK_SIZE:    block_size_r    <= cfg_data;
        default:           blocks_in_use_r <= blocks_in_use_r;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    len_r         <= len_nxt;
    idx_r         <= idx_nxt;
    val_r         <= val_nxt;
    scan_ptr_r    <= scan_ptr_nxt;
    pend_addr_r   <= pend_addr_nxt;
    cur_r         <= cur_nxt;
    linked_r      <= linked_nxt;
    acc_r         <= acc_nxt;
    start_block_r <= start_block_nxt;
    no_space_r    <= no_space_nxt;
    read_value_r  <= read_value_nxt;
  end

  // Result word.
  assign out_valid         = ctl.strobe;
  assign out_start_block   = start_block_r;
  assign out_blocks_linked = linked_r;
  assign out_no_space      = no_space_r;
  assign out_read_value    = read_value_r;

  // An accepted request always leaves the idle step.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not start work");

  // Exactly one result cycle per request.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result shown for more than one cycle");

  // The scan never considers entry zero.
  a_skip_entry0: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_addr_r != '0))
    else $error("scan reached entry zero");

  // A chain is only terminated after at least one block was placed.
  a_term_linked: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == U_TERM) |-> (linked_r != '0))
    else $error("terminating an empty chain");

endmodule
